FILE: rtl/core/kdmc_pkg.sv
// kdmc_pkg: shared types and constants for the knob deadband to midi cc block
// no dependencies; imported by every module of the block

package kdmc_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CC_STATUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_CTRL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_VALUE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_CTRL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAL_BASE = 3'd6;

	localparam logic [9:0] RST_DEADBAND = 10'd5;
	localparam logic [3:0] RST_BANK_COUNT = 4'd3;
	localparam logic [7:0] RST_CC_STATUS = 8'd176;
	localparam logic [6:0] RST_SWITCH_CTRL = 7'd1;
	localparam logic [6:0] RST_SWITCH_VALUE = 7'd127;
	localparam logic [6:0] RST_VOLUME_CTRL = 7'd2;
	localparam logic [6:0] RST_DIAL_BASE = 7'd3;

	localparam logic [6:0] CC_VALUE_MAX = 7'd127;

	typedef enum logic [1:0] {
		FUNC_DIAL = 2'd0,
		FUNC_VOLUME = 2'd1,
		FUNC_ENCODER = 2'd2,
		FUNC_SWITCH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_DIAL = 2'd0,
		OP_VOLUME = 2'd1,
		OP_FIXED = 2'd2
	} op_t;

	typedef struct packed {
		logic [9:0] deadband;
		logic [3:0] bank_count;
		logic [7:0] cc_status;
		logic [6:0] switch_ctrl;
		logic [6:0] switch_value;
		logic [6:0] volume_ctrl;
		logic [6:0] dial_base;
	} cfg_t;

	typedef struct packed {
		op_t op;
		logic [6:0] ctrl;
		logic [SAMPLE_W-1:0] smp;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: rtl/core/kdmc_front.sv
// kdmc_front: accepts events, applies deadband and encoder bank logic
// depends on kdmc_pkg; pushes message commands into kdmc_queue

module kdmc_front import kdmc_pkg::*; #(
	parameter int NUM_DIALS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                accept,
	input  logic [1:0]          func,
	input  logic [3:0]          dial_index,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                step_forward,
	input  logic                switch_level,
	output logic                push,
	output cmd_t                cmd
);

	localparam int DW = (NUM_DIALS > 1) ? $clog2(NUM_DIALS) : 1;

	logic [SAMPLE_W-1:0] dial_last_q [NUM_DIALS];
	logic [SAMPLE_W-1:0] volume_last_q;
	logic [4:0]          hc_q;
	logic [3:0]          bank_q;
	logic                switch_prev_q;

	logic                dial_ok;
	logic [DW-1:0]       dsel;
	logic [SAMPLE_W-1:0] dial_last;
	logic                dial_moved;
	logic                vol_moved;
	logic [3:0]          banks;
	logic [4:0]          two_b;
	logic [4:0]          hc_next;
	logic                rising;
	logic [9:0]          dial_sum;
	func_t               fn;

	function automatic logic moved(input logic [SAMPLE_W-1:0] now,
			input logic [SAMPLE_W-1:0] last, input logic [9:0] band);
		logic [SAMPLE_W-1:0] d;
		d = (now > last) ? now - last : last - now;
		return d > band;
	endfunction

	// restoring remainder, quotient fits four bits
	function automatic logic [4:0] mod_small(input logic [5:0] a, input logic [4:0] m);
		logic [9:0] r;
		r = 10'(a);
		for (int i = 3; i >= 0; i--) begin
			if (r >= (10'(m) << i)) begin
				r = r - (10'(m) << i);
			end
		end
		return r[4:0];
	endfunction

	always_comb begin
		fn = func_t'(func);
		dial_ok = {1'b0, dial_index} < 5'(NUM_DIALS);
		dsel = dial_index[DW-1:0];
		dial_last = dial_ok ? dial_last_q[dsel] : '0;
		dial_moved = moved(sample, dial_last, cfg.deadband);
		vol_moved = moved(sample, volume_last_q, cfg.deadband);
		banks = (cfg.bank_count == 4'd0) ? 4'd1 : cfg.bank_count;
		two_b = {banks, 1'b0};
		if (step_forward) begin
			hc_next = mod_small(6'(hc_q) + 6'd1, two_b);
		end else if (hc_q == 5'd0) begin
			hc_next = two_b - 5'd2;
		end else begin
			hc_next = hc_q - 5'd1;
		end
		rising = switch_level & ~switch_prev_q;
		dial_sum = 10'(cfg.dial_base) + 10'(dial_index) + 10'(bank_q) * 10'(NUM_DIALS);

		push = 1'b0;
		cmd.op = OP_FIXED;
		cmd.ctrl = cfg.switch_ctrl;
		cmd.smp = SAMPLE_W'(cfg.switch_value);
		case (fn)
			FUNC_DIAL: begin
				push = accept & dial_ok & dial_moved;
				cmd.op = OP_DIAL;
				cmd.ctrl = dial_sum[6:0];
				cmd.smp = sample;
			end
			FUNC_VOLUME: begin
				push = accept & vol_moved;
				cmd.op = OP_VOLUME;
				cmd.ctrl = cfg.volume_ctrl;
				cmd.smp = sample;
			end
			FUNC_SWITCH: begin
				push = accept & rising;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIALS; i++) begin
				dial_last_q[i] <= '0;
			end
			volume_last_q <= '0;
			hc_q <= '0;
			bank_q <= '0;
			switch_prev_q <= 1'b0;
		end else if (accept) begin
			case (fn)
				FUNC_DIAL: begin
					if (dial_ok && dial_moved) begin
						dial_last_q[dsel] <= sample;
					end
				end
				FUNC_VOLUME: begin
					if (vol_moved) begin
						volume_last_q <= sample;
					end
				end
				FUNC_ENCODER: begin
					hc_q <= hc_next;
					bank_q <= hc_next[4:1];
				end
				FUNC_SWITCH: begin
					switch_prev_q <= switch_level;
					if (rising) begin
						hc_q <= '0;
					end
				end
				default: begin
					hc_q <= hc_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/kdmc_queue.sv
// kdmc_queue: short command queue between front and back
// depends on kdmc_pkg for the command type and depth

module kdmc_queue import kdmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t status
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	always_comb begin
		head = mem_q[rd_ptr_q];
		status.full = (count_q == QUEUE_CW'(QUEUE_DEPTH));
		status.empty = (count_q == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/kdmc_back.sv
// kdmc_back: scales samples to 7 bits and holds the outgoing message beat
// depends on kdmc_pkg; pops commands from kdmc_queue

module kdmc_back import kdmc_pkg::*; #(
	parameter int SAMPLE_MAX = 1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] cc_status,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] status_byte,
	output logic [6:0] data_first,
	output logic [6:0] data_second
);

	// exact floor(p / SAMPLE_MAX) by reciprocal, p below 2**PW
	localparam int PW = SAMPLE_W + 7;
	localparam int MW = $clog2(SAMPLE_MAX + 1);
	localparam int K = PW + MW;
	localparam longint RECIP = ((64'd1 << K) + SAMPLE_MAX - 1) / SAMPLE_MAX;
	localparam int RW = K - 7;
	localparam int XW = PW + RW;

	logic                valid_s1;
	op_t                 op_s1;
	logic [6:0]          ctrl_s1;
	logic [6:0]          fixed_s1;
	logic [XW-1:0]       prod_s1;

	logic                out_valid_q;
	logic [7:0]          status_q;
	logic [6:0]          first_q;
	logic [6:0]          second_q;

	logic                out_adv;
	logic                s1_adv;
	logic [SAMPLE_W-1:0] clamped;
	logic [PW-1:0]       scaled;
	logic [6:0]          quot;
	logic [6:0]          value;

	always_comb begin
		out_adv = !out_valid_q || !out_stall;
		s1_adv = !valid_s1 || out_adv;
		pop = !empty && s1_adv;
		clamped = ({3'b000, head.smp} > 13'(SAMPLE_MAX)) ?
			SAMPLE_W'(SAMPLE_MAX) : head.smp;
		scaled = {clamped, 7'b0000000} - PW'(clamped);
		quot = prod_s1[K+6:K];
		case (op_s1)
			OP_DIAL: value = CC_VALUE_MAX - quot;
			OP_VOLUME: value = quot;
			OP_FIXED: value = fixed_s1;
			default: value = fixed_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= head.op;
			ctrl_s1 <= head.ctrl;
			fixed_s1 <= head.smp[6:0];
			prod_s1 <= XW'(scaled) * XW'(RW'(RECIP));
		end
		if (valid_s1 && out_adv) begin
			status_q <= cc_status;
			first_q <= ctrl_s1;
			second_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= pop;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status_byte = status_q;
	assign data_first = first_q;
	assign data_second = second_q;

endmodule

FILE: rtl/core/knob_deadband_to_midi_cc.sv
// knob_deadband_to_midi_cc: top level, configuration registers and block wiring
// depends on kdmc_pkg, kdmc_front, kdmc_queue and kdmc_back

// Takes one event per clock while in_stall is low: dial and volume samples,
// encoder steps and switch levels, and turns moved knobs and rising switch
// edges into midi control change messages. All state updates happen in the
// front in the cycle an event is accepted, so events may arrive every cycle
// with no gaps. A message passes through the queue, the scaling multiply
// register and the output register on its way out; a four-entry queue lets
// the output stall while events keep flowing, and in_stall rises only when
// that queue is full. Configuration writes are always taken (cfg_ready is
// tied high) and must be made while no message is pending.

module knob_deadband_to_midi_cc import kdmc_pkg::*; #(
	parameter int NUM_DIALS = 10,
	parameter int SAMPLE_MAX = 1023
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            func,
	input  logic [3:0]            dial_index,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  step_forward,
	input  logic                  switch_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            status_byte,
	output logic [6:0]            data_first,
	output logic [6:0]            data_second
);

	cfg_t          cfg_q;
	logic          accept;
	logic          push;
	logic          pop;
	cmd_t          push_cmd;
	cmd_t          head;
	queue_status_t qst;

	assign cfg_ready = 1'b1;
	assign in_stall = qst.full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband <= RST_DEADBAND;
			cfg_q.bank_count <= RST_BANK_COUNT;
			cfg_q.cc_status <= RST_CC_STATUS;
			cfg_q.switch_ctrl <= RST_SWITCH_CTRL;
			cfg_q.switch_value <= RST_SWITCH_VALUE;
			cfg_q.volume_ctrl <= RST_VOLUME_CTRL;
			cfg_q.dial_base <= RST_DIAL_BASE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEADBAND: cfg_q.deadband <= cfg_data;
				CFG_BANK_COUNT: cfg_q.bank_count <= cfg_data[3:0];
				CFG_CC_STATUS: cfg_q.cc_status <= cfg_data[7:0];
				CFG_SWITCH_CTRL: cfg_q.switch_ctrl <= cfg_data[6:0];
				CFG_SWITCH_VALUE: cfg_q.switch_value <= cfg_data[6:0];
				CFG_VOLUME_CTRL: cfg_q.volume_ctrl <= cfg_data[6:0];
				CFG_DIAL_BASE: cfg_q.dial_base <= cfg_data[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	kdmc_front #(
		.NUM_DIALS(NUM_DIALS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.func(func),
		.dial_index(dial_index),
		.sample(sample),
		.step_forward(step_forward),
		.switch_level(switch_level),
		.push(push),
		.cmd(push_cmd)
	);

	kdmc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head(head),
		.status(qst)
	);

	kdmc_back #(
		.SAMPLE_MAX(SAMPLE_MAX)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cc_status(cfg_q.cc_status),
		.head(head),
		.empty(qst.empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status_byte(status_byte),
		.data_first(data_first),
		.data_second(data_second)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qst.full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qst.empty |-> !pop)
		else $error("queue read while empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !qst.empty)
		else $error("queue empty after a beat was written");
`endif

endmodule

FILE: tb/sv/kdmc_cc_checker.sv
`timescale 1ns / 1ps
// kdmc_cc_checker: watches the settings, event and message channels of the knob scanner,
// predicts every control change beat and compares it with what the block sends
// depends on kdmc_pkg

module kdmc_cc_checker import kdmc_pkg::*; #(
	parameter int NUM_DIALS = 10,
	parameter int SAMPLE_MAX = 1023
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            func,
	input  logic [3:0]            dial_index,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  step_forward,
	input  logic                  switch_level,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [7:0]            status_byte,
	input  logic [6:0]            data_first,
	input  logic [6:0]            data_second,
	output int                    msgs_pending,
	output int                    fail_count
);

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] ctrl;
		logic [6:0] value;
	} cc_msg_t;

	cfg_t                regs;
	logic [SAMPLE_W-1:0] dial_sent [NUM_DIALS];
	logic [SAMPLE_W-1:0] volume_sent;
	logic [4:0]          half_steps;
	logic [3:0]          bank;
	logic                switch_was;
	cc_msg_t             expected_msgs [$];

	function automatic logic [6:0] cc_value(input logic [SAMPLE_W-1:0] v);
		int unsigned scaled;
		scaled = 32'(v) * 32'(CC_VALUE_MAX) / 32'(SAMPLE_MAX);
		return (scaled > 32'(CC_VALUE_MAX)) ? CC_VALUE_MAX : scaled[6:0];
	endfunction

	function automatic bit moved_past(input logic [SAMPLE_W-1:0] now, input logic [SAMPLE_W-1:0] last);
		int unsigned a, b;
		a = 32'(now);
		b = 32'(last);
		return ((a > b) ? a - b : b - a) > 32'(regs.deadband);
	endfunction

	// updates the knob state for one event; returns 1 when a message goes out
	function automatic bit knob_event_to_cc(input func_t kind, input logic [3:0] idx,
			input logic [SAMPLE_W-1:0] smp, input logic fwd, input logic lvl,
			output cc_msg_t msg);
		int unsigned banks, ctrl, steps;
		bit rising;
		msg.status = regs.cc_status;
		msg.ctrl = '0;
		msg.value = '0;
		banks = (regs.bank_count == 4'd0) ? 1 : 32'(regs.bank_count);
		case (kind)
			FUNC_DIAL: begin
				if (32'(idx) >= NUM_DIALS)
					return 1'b0;
				if (!moved_past(smp, dial_sent[idx]))
					return 1'b0;
				dial_sent[idx] = smp;
				ctrl = 32'(regs.dial_base) + 32'(idx) + 32'(bank) * NUM_DIALS;
				msg.ctrl = ctrl[6:0];
				msg.value = CC_VALUE_MAX - cc_value(smp);
				return 1'b1;
			end
			FUNC_VOLUME: begin
				if (!moved_past(smp, volume_sent))
					return 1'b0;
				volume_sent = smp;
				msg.ctrl = regs.volume_ctrl;
				msg.value = cc_value(smp);
				return 1'b1;
			end
			FUNC_ENCODER: begin
				steps = 32'(half_steps);
				if (fwd)
					steps = (steps + 1) % (2 * banks);
				else if (steps == 0)
					steps = 2 * banks - 2;
				else
					steps = steps - 1;
				half_steps = steps[4:0];
				bank = half_steps[4:1];
				return 1'b0;
			end
			default: begin
				// rising edge clears the half-step count but keeps the bank
				rising = lvl && !switch_was;
				switch_was = lvl;
				if (!rising)
					return 1'b0;
				half_steps = '0;
				msg.ctrl = regs.switch_ctrl;
				msg.value = regs.switch_value;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int errs;
		cc_msg_t seen, want, predicted;
		if (!arst_n) begin
			regs.deadband = RST_DEADBAND;
			regs.bank_count = RST_BANK_COUNT;
			regs.cc_status = RST_CC_STATUS;
			regs.switch_ctrl = RST_SWITCH_CTRL;
			regs.switch_value = RST_SWITCH_VALUE;
			regs.volume_ctrl = RST_VOLUME_CTRL;
			regs.dial_base = RST_DIAL_BASE;
			foreach (dial_sent[i])
				dial_sent[i] = '0;
			volume_sent = '0;
			half_steps = '0;
			bank = '0;
			switch_was = 1'b0;
			expected_msgs.delete();
			msgs_pending <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			// an outgoing beat always belongs to an event taken at an earlier edge
			if (out_valid && !out_stall) begin
				seen = {status_byte, data_first, data_second};
				if (expected_msgs.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %0d %0d %0d",
						$time, seen.status, seen.ctrl, seen.value);
					errs++;
				end else begin
					want = expected_msgs.pop_front();
					errs += field_differs("status_byte", want.status, seen.status);
					errs += field_differs("data_first", {1'b0, want.ctrl}, {1'b0, seen.ctrl});
					errs += field_differs("data_second", {1'b0, want.value}, {1'b0, seen.value});
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEADBAND:     regs.deadband = cfg_data[9:0];
					CFG_BANK_COUNT:   regs.bank_count = cfg_data[3:0];
					CFG_CC_STATUS:    regs.cc_status = cfg_data[7:0];
					CFG_SWITCH_CTRL:  regs.switch_ctrl = cfg_data[6:0];
					CFG_SWITCH_VALUE: regs.switch_value = cfg_data[6:0];
					CFG_VOLUME_CTRL:  regs.volume_ctrl = cfg_data[6:0];
					CFG_DIAL_BASE:    regs.dial_base = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (knob_event_to_cc(func_t'(func), dial_index, sample, step_forward,
						switch_level, predicted))
					expected_msgs.push_back(predicted);
			end
			fail_count <= fail_count + errs;
			msgs_pending <= expected_msgs.size();
		end
	end

endmodule

FILE: tb/sv/knob_deadband_to_midi_cc_test.sv
`timescale 1ns / 1ps
// knob_deadband_to_midi_cc_test: testbench top, drives knob events, settings and output stalls
// depends on kdmc_pkg, knob_deadband_to_midi_cc and kdmc_cc_checker

module knob_deadband_to_midi_cc_test;
	import kdmc_pkg::*;

	localparam int NUM_DIALS = 10;
	localparam int VOLUME_KNOB = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_EVENTS = 230;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            func;
	logic [3:0]            dial_index;
	logic [SAMPLE_W-1:0]   sample;
	logic                  step_forward;
	logic                  switch_level;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            status_byte;
	logic [6:0]            data_first;
	logic [6:0]            data_second;

	int msgs_pending;
	int fail_count;
	int cycles = 0;
	int holds_asked = 0;
	int holds_done = 0;
	bit stalls_on = 1'b0;
	bit gaps_on = 1'b0;
	int knob_pos [VOLUME_KNOB + 1];

	knob_deadband_to_midi_cc DUT (.*);

	kdmc_cc_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin : output_stalls
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = stalls_on ? gap_len() : 0;
			if (holds_done < holds_asked) begin
				// long hold-off so the internal queue fills and the input stalls
				hold = LONG_HOLD;
				holds_done++;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (stalls_on ? 1 + gap_len() : 1) @(posedge clk);
		end
	end

	task automatic send_event(input func_t kind, input logic [3:0] idx,
			input logic [SAMPLE_W-1:0] smp, input logic fwd, input logic lvl);
		int gap;
		in_valid <= 1'b1;
		func <= kind;
		dial_index <= idx;
		sample <= smp;
		step_forward <= fwd;
		switch_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = gaps_on ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_event();
		func_t kind;
		logic [3:0] idx;
		int r, slot, pos;
		r = $urandom_range(0, 99);
		if (r < 45)
			kind = FUNC_DIAL;
		else if (r < 60)
			kind = FUNC_VOLUME;
		else if (r < 82)
			kind = FUNC_ENCODER;
		else
			kind = FUNC_SWITCH;
		if ($urandom_range(0, 9) == 0)
			idx = 4'($urandom_range(NUM_DIALS, 15));
		else
			idx = 4'($urandom_range(0, NUM_DIALS - 1));
		slot = (kind == FUNC_VOLUME) ? VOLUME_KNOB : int'(idx);
		// a third of the samples hover around the knob's last position
		if ($urandom_range(0, 2) == 0)
			pos = knob_pos[slot] + int'($urandom_range(0, 16)) - 8;
		else
			pos = int'($urandom_range(0, 1023));
		if (pos < 0)
			pos = 0;
		if (pos > 1023)
			pos = 1023;
		knob_pos[slot] = pos;
		send_event(kind, idx, pos[SAMPLE_W-1:0], 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (msgs_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
			input int width);
		int unsigned mask, data;
		// bits above the register width carry noise
		mask = (32'd1 << width) - 1;
		data = ($urandom & ~mask) | (value & mask);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_settings(input int unsigned db, input int unsigned banks,
			input int unsigned status, input int unsigned sw_ctrl, input int unsigned sw_val,
			input int unsigned vol_ctrl, input int unsigned base);
		write_reg(CFG_DEADBAND, db, 10);
		write_reg(CFG_BANK_COUNT, banks, 4);
		write_reg(CFG_CC_STATUS, status, 8);
		write_reg(CFG_SWITCH_CTRL, sw_ctrl, 7);
		write_reg(CFG_SWITCH_VALUE, sw_val, 7);
		write_reg(CFG_VOLUME_CTRL, vol_ctrl, 7);
		write_reg(CFG_DIAL_BASE, base, 7);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_settings();
		int unsigned db;
		if ($urandom_range(0, 3) == 0)
			db = $urandom_range(0, 1023);
		else
			db = $urandom_range(0, 24);
		load_settings(db, $urandom_range(0, 15), $urandom_range(0, 255),
			$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 127));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		dial_index = '0;
		sample = '0;
		step_forward = 1'b0;
		switch_level = 1'b0;
		foreach (knob_pos[i])
			knob_pos[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: deadband edges, range limits, bank moves, switch edges
		send_event(FUNC_DIAL, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd0, 10'd5, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd0, 10'd6, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd9, 10'd1023, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd10, 10'd1023, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd15, 10'd512, 1'b1, 1'b1);
		send_event(FUNC_VOLUME, 4'd0, 10'd1023, 1'b0, 1'b0);
		send_event(FUNC_VOLUME, 4'd0, 10'd1020, 1'b0, 1'b0);
		send_event(FUNC_VOLUME, 4'd0, 10'd0, 1'b0, 1'b0);
		repeat (3) send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b1, 1'b0);
		send_event(FUNC_DIAL, 4'd4, 10'd700, 1'b0, 1'b0);
		repeat (4) send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd9, 10'd300, 1'b0, 1'b0);
		send_event(FUNC_SWITCH, 4'd0, 10'd0, 1'b0, 1'b1);
		send_event(FUNC_SWITCH, 4'd0, 10'd0, 1'b0, 1'b1);
		send_event(FUNC_SWITCH, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_SWITCH, 4'd0, 10'd0, 1'b0, 1'b1);
		send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd2, 10'd1, 1'b0, 1'b0);
		drain();

		// lowest settings, bank count of zero acts as one
		write_reg(CFG_UNUSED, $urandom, 10);
		load_settings(0, 0, 128, 0, 0, 0, 0);
		send_event(FUNC_DIAL, 4'd1, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd1, 10'd1, 1'b0, 1'b0);
		repeat (2) send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b1, 1'b0);
		repeat (2) send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_VOLUME, 4'd0, 10'd1, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd3, 10'd1023, 1'b0, 1'b0);
		drain();

		// highest settings: nothing moves far enough past the deadband
		stalls_on = 1'b1;
		gaps_on = 1'b1;
		load_settings(1023, 15, 255, 127, 127, 127, 127);
		repeat (100) send_random_event();
		drain();

		// top bank with controller numbers wrapping past seven bits
		stalls_on = 1'b0;
		gaps_on = 1'b0;
		load_settings(0, 15, 255, 127, 127, 127, 127);
		repeat (29) send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b1, 1'b0);
		send_event(FUNC_DIAL, 4'd9, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd9, 10'd1023, 1'b0, 1'b0);
		send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd9, 10'd500, 1'b0, 1'b0);
		drain();

		// bank count shrinks below the current half-step count
		load_settings(5, 2, 176, 1, 127, 2, 3);
		send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd0, 10'd100, 1'b0, 1'b0);
		send_event(FUNC_DIAL, 4'd0, 10'd200, 1'b0, 1'b0);
		send_event(FUNC_ENCODER, 4'd0, 10'd0, 1'b1, 1'b0);
		send_event(FUNC_DIAL, 4'd0, 10'd300, 1'b0, 1'b0);
		drain();

		for (int p = 0; p < 8; p++) begin
			stalls_on = (p % 4 == 0) || (p % 4 == 2);
			gaps_on = (p % 4 == 0) || (p % 4 == 3);
			load_random_settings();
			if (p == 2)
				holds_asked++;
			repeat (PHASE_EVENTS) send_random_event();
			drain();
		end

		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
